### hdl/lfss_pkg.sv
// Shared constants, types and helper functions of the line follower controller.
`timescale 1ns / 1ps

package lfss_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int ADC_BITS     = 12;
    localparam int SENSOR_COUNT = 5;

    localparam int DUTY_W  = FRAC_BITS + 1;      // 0 .. 1.0 in Q12
    localparam int OFF_W   = FRAC_BITS + 2;      // -1.0 .. 1.0 in Q12
    localparam int WIDE_W  = FRAC_BITS + 4;      // room for drive +/- step
    localparam int PROD_W  = 2 * DUTY_W;         // magnitude times growth factor
    localparam int PULSE_W = 12;
    localparam int SUM_W   = PULSE_W + 1;
    localparam int TICK_W  = 16;
    localparam int POS_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam int Q_ONE      = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int GROW_NUM   = ((11 << FRAC_BITS) + 5) / 10;   // 1.1
    localparam int BASE_RESET = ((6 << FRAC_BITS) + 5) / 10;    // 0.6

    // sensor positions, far left to far right
    localparam logic [POS_W-1:0] POS_FAR_LEFT   = 3'd0;
    localparam logic [POS_W-1:0] POS_NEAR_LEFT  = 3'd1;
    localparam logic [POS_W-1:0] POS_CENTER     = 3'd2;
    localparam logic [POS_W-1:0] POS_NEAR_RIGHT = 3'd3;
    localparam logic [POS_W-1:0] POS_FAR_RIGHT  = 3'd4;
    localparam logic [POS_W-1:0] POS_NONE       = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE_SUM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE_SUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DOWN_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_UP_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_OFFSET     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_OFFSET      = 3'd7;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_SPEED  = 2'd1,
        OP_TICK   = 2'd2,
        OP_TOGGLE = 2'd3
    } op_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]       white_threshold;
        logic signed [SUM_W-1:0]   min_pulse_sum;
        logic signed [SUM_W-1:0]   max_pulse_sum;
        logic [TICK_W-1:0]         stop_ticks;
        logic [DUTY_W-1:0]         speed_down_step;
        logic [DUTY_W-1:0]         speed_up_step;
        logic [DUTY_W-1:0]         near_offset;
        logic [DUTY_W-1:0]         far_offset;
    } cfg_t;

    typedef struct packed {
        logic                      found;
        logic [POS_W-1:0]          pos;
        logic signed [OFF_W-1:0]   offset;
    } pick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [POS_W-1:0]  line_position;
        logic              motors_enabled;
        logic              halted;
    } res_t;

    // saturate a wide signed value into 0 .. Q_ONE
    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [WIDE_W-1:0] v);
        logic [DUTY_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > WIDE_W'(Q_ONE))
            r = DUTY_W'(Q_ONE);
        else
            r = v[DUTY_W-1:0];
        return r;
    endfunction

endpackage

### hdl/line_follower_steering_speed.sv
// Top level of the line follower steering and speed controller.
`timescale 1ns / 1ps

// Steering and speed control for a five-sensor line follower. Each input word
// carries an operation (sensor scan, encoder speed sample, time tick, enable
// toggle) and returns exactly one result word with both motor duties (Q12,
// 4096 is full), the last line position, the enable flag and the halt flag.
// Timing: one word per clock cycle sustained while out_stall is low; the result
// of a word is registered at acceptance. Five compare lanes, the priority
// merge and the state update all complete in the cycle of acceptance, so a
// word can follow in the next cycle. Results go through an output register
// backed by one skid entry; in_stall rises only when both are full, i.e. after
// downstream has stalled for two words. Configuration writes on cfg_we land
// on the next edge and must be issued while no words are in flight. After the
// end-of-track stop fires the block ignores every operation and reports both
// duties at full scale until reset.

module line_follower_steering_speed (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [lfss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lfss_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            operation,
    input  logic [lfss_pkg::ADC_BITS-1:0]         sensor_0,
    input  logic [lfss_pkg::ADC_BITS-1:0]         sensor_1,
    input  logic [lfss_pkg::ADC_BITS-1:0]         sensor_2,
    input  logic [lfss_pkg::ADC_BITS-1:0]         sensor_3,
    input  logic [lfss_pkg::ADC_BITS-1:0]         sensor_4,
    input  logic signed [lfss_pkg::PULSE_W-1:0]   left_pulses,
    input  logic signed [lfss_pkg::PULSE_W-1:0]   right_pulses,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lfss_pkg::DUTY_W-1:0]           left_duty,
    output logic [lfss_pkg::DUTY_W-1:0]           right_duty,
    output logic [lfss_pkg::POS_W-1:0]            line_position,
    output logic                                  motors_enabled,
    output logic                                  halted
);

    lfss_pkg::cfg_t                 cfg_reg, cfg_next;
    logic [lfss_pkg::ADC_BITS-1:0]  sens [lfss_pkg::SENSOR_COUNT];
    logic [lfss_pkg::SENSOR_COUNT-1:0] white;
    lfss_pkg::pick_t                pick;
    lfss_pkg::res_t                 res;
    lfss_pkg::res_t                 res_out;
    logic                           accept;
    logic                           full;

    // ---------------------------------------------------------------
    // Configuration registers: write-only, one index per register.
    // ---------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lfss_pkg::CFG_WHITE_THRESHOLD:
                    cfg_next.white_threshold = cfg_data[lfss_pkg::ADC_BITS-1:0];
                lfss_pkg::CFG_MIN_PULSE_SUM:
                    cfg_next.min_pulse_sum = $signed(cfg_data[lfss_pkg::SUM_W-1:0]);
                lfss_pkg::CFG_MAX_PULSE_SUM:
                    cfg_next.max_pulse_sum = $signed(cfg_data[lfss_pkg::SUM_W-1:0]);
                lfss_pkg::CFG_STOP_TICKS:
                    cfg_next.stop_ticks = cfg_data[lfss_pkg::TICK_W-1:0];
                lfss_pkg::CFG_SPEED_DOWN_STEP:
                    cfg_next.speed_down_step = cfg_data[lfss_pkg::DUTY_W-1:0];
                lfss_pkg::CFG_SPEED_UP_STEP:
                    cfg_next.speed_up_step = cfg_data[lfss_pkg::DUTY_W-1:0];
                lfss_pkg::CFG_NEAR_OFFSET:
                    cfg_next.near_offset = cfg_data[lfss_pkg::DUTY_W-1:0];
                lfss_pkg::CFG_FAR_OFFSET:
                    cfg_next.far_offset = cfg_data[lfss_pkg::DUTY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.white_threshold <= 12'd1737;     // 1.4 V of 3.3 V
            cfg_reg.min_pulse_sum   <= 13'sd63;
            cfg_reg.max_pulse_sum   <= 13'sd188;
            cfg_reg.stop_ticks      <= 16'd400;
            cfg_reg.speed_down_step <= 13'd205;      // 0.05
            cfg_reg.speed_up_step   <= 13'd410;      // 0.1
            cfg_reg.near_offset     <= 13'd102;      // 0.025
            cfg_reg.far_offset      <= 13'd328;      // 0.08
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Input handshake: stall only when the result buffer is full.
    // ---------------------------------------------------------------
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Sensor lanes: one threshold compare per sensor, side by side.
    // ---------------------------------------------------------------
    assign sens[0] = sensor_0;
    assign sens[1] = sensor_1;
    assign sens[2] = sensor_2;
    assign sens[3] = sensor_3;
    assign sens[4] = sensor_4;

    for (genvar g = 0; g < lfss_pkg::SENSOR_COUNT; g++)
    begin : g_lane
        lfss_lane u_lane (
            .sample    (sens[g]),
            .threshold (cfg_reg.white_threshold),
            .white     (white[g])
        );
    end

    // Merge: centre, near-left, near-right, far-left, far-right.
    lfss_pick u_pick (
        .white       (white),
        .near_offset (cfg_reg.near_offset),
        .far_offset  (cfg_reg.far_offset),
        .pick        (pick)
    );

    // ---------------------------------------------------------------
    // State update; one result per accepted word.
    // ---------------------------------------------------------------
    lfss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .left_pulses  (left_pulses),
        .right_pulses (right_pulses),
        .pick         (pick),
        .cfg          (cfg_reg),
        .res          (res)
    );

    // Result buffer: output register plus skid entry.
    lfss_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res_out),
        .full      (full)
    );

    assign left_duty      = res_out.left_duty;
    assign right_duty     = res_out.right_duty;
    assign line_position  = res_out.line_position;
    assign motors_enabled = res_out.motors_enabled;
    assign halted         = res_out.halted;

endmodule

### hdl/lfss_lane.sv
// One sensor lane: threshold compare of a single ADC sample.
`timescale 1ns / 1ps

module lfss_lane (
    input  logic [lfss_pkg::ADC_BITS-1:0] sample,
    input  logic [lfss_pkg::ADC_BITS-1:0] threshold,
    output logic                          white
);

    assign white = (sample > threshold);

endmodule

### hdl/lfss_pick.sv
// Merge stage: priority pick of the line position and its steering offset.
`timescale 1ns / 1ps

module lfss_pick (
    input  logic [lfss_pkg::SENSOR_COUNT-1:0] white,
    input  logic [lfss_pkg::DUTY_W-1:0]       near_offset,
    input  logic [lfss_pkg::DUTY_W-1:0]       far_offset,
    output lfss_pkg::pick_t                   pick
);

    logic signed [lfss_pkg::OFF_W-1:0] near_c;
    logic signed [lfss_pkg::OFF_W-1:0] far_c;

    // clamp the configured magnitudes to full scale
    assign near_c = (near_offset > lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE)) ?
                    lfss_pkg::OFF_W'(lfss_pkg::Q_ONE) : $signed({1'b0, near_offset});
    assign far_c  = (far_offset > lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE)) ?
                    lfss_pkg::OFF_W'(lfss_pkg::Q_ONE) : $signed({1'b0, far_offset});

    // centre first, then inner pair, then outer pair
    always_comb
    begin
        pick.found  = 1'b1;
        pick.pos    = lfss_pkg::POS_NONE;
        pick.offset = '0;
        priority if (white[lfss_pkg::POS_CENTER])
        begin
            pick.pos = lfss_pkg::POS_CENTER;
        end
        else if (white[lfss_pkg::POS_NEAR_LEFT])
        begin
            pick.pos    = lfss_pkg::POS_NEAR_LEFT;
            pick.offset = near_c;
        end
        else if (white[lfss_pkg::POS_NEAR_RIGHT])
        begin
            pick.pos    = lfss_pkg::POS_NEAR_RIGHT;
            pick.offset = -near_c;
        end
        else if (white[lfss_pkg::POS_FAR_LEFT])
        begin
            pick.pos    = lfss_pkg::POS_FAR_LEFT;
            pick.offset = far_c;
        end
        else if (white[lfss_pkg::POS_FAR_RIGHT])
        begin
            pick.pos    = lfss_pkg::POS_FAR_RIGHT;
            pick.offset = -far_c;
        end
        else
        begin
            pick.found = 1'b0;
        end
    end

endmodule

### hdl/lfss_ctrl.sv
// Controller state: steering, base drive, stop timer and the result of each word.
`timescale 1ns / 1ps

module lfss_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [1:0]                           operation,
    input  logic signed [lfss_pkg::PULSE_W-1:0]  left_pulses,
    input  logic signed [lfss_pkg::PULSE_W-1:0]  right_pulses,
    input  lfss_pkg::pick_t                      pick,
    input  lfss_pkg::cfg_t                       cfg,
    output lfss_pkg::res_t                       res
);

    logic                               enabled_reg,  enabled_next;
    logic                               halted_reg,   halted_next;
    logic                               running_reg,  running_next;
    logic [lfss_pkg::TICK_W-1:0]        count_reg,    count_next;
    logic [lfss_pkg::DUTY_W-1:0]        base_reg,     base_next;
    logic signed [lfss_pkg::OFF_W-1:0]  offset_reg,   offset_next;
    logic [lfss_pkg::POS_W-1:0]         line_reg,     line_next;
    logic signed [lfss_pkg::SUM_W-1:0]  latest_reg,   latest_next;
    logic signed [lfss_pkg::SUM_W-1:0]  held_reg,     held_next;
    logic [lfss_pkg::DUTY_W-1:0]        left_reg,     left_next;
    logic [lfss_pkg::DUTY_W-1:0]        right_reg,    right_next;

    lfss_pkg::op_t                      op;
    logic signed [lfss_pkg::OFF_W-1:0]  off_v;
    logic signed [lfss_pkg::WIDE_W-1:0] off_wide;
    logic [lfss_pkg::DUTY_W-1:0]        base_v;
    logic                               stop_hit;

    // offset times 1.1, rounded half away from zero, saturated to full scale
    function automatic logic signed [lfss_pkg::OFF_W-1:0] grow(
        input logic signed [lfss_pkg::OFF_W-1:0] off
    );
        logic [lfss_pkg::OFF_W-1:0]  mag_full;
        logic [lfss_pkg::DUTY_W-1:0] mag;
        logic [lfss_pkg::PROD_W-1:0] prod;
        logic [lfss_pkg::OFF_W-1:0]  rnd;
        mag_full = off[lfss_pkg::OFF_W-1] ? lfss_pkg::OFF_W'(-off) : off;
        mag      = mag_full[lfss_pkg::DUTY_W-1:0];
        prod     = lfss_pkg::PROD_W'(mag) * lfss_pkg::PROD_W'(lfss_pkg::GROW_NUM);
        prod     = prod + lfss_pkg::PROD_W'(lfss_pkg::ROUND_HALF);
        rnd      = prod[lfss_pkg::FRAC_BITS +: lfss_pkg::OFF_W];
        if (rnd > lfss_pkg::OFF_W'(lfss_pkg::Q_ONE))
            rnd = lfss_pkg::OFF_W'(lfss_pkg::Q_ONE);
        return off[lfss_pkg::OFF_W-1] ? -$signed(rnd) : $signed(rnd);
    endfunction

    assign op = lfss_pkg::op_t'(operation);

    always_comb
    begin
        enabled_next = enabled_reg;
        halted_next  = halted_reg;
        running_next = running_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        offset_next  = offset_reg;
        line_next    = line_reg;
        latest_next  = latest_reg;
        held_next    = held_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        off_v        = offset_reg;
        off_wide     = '0;
        base_v       = base_reg;
        stop_hit     = 1'b0;

        if (accept && !halted_reg)
        begin
            unique case (op)
                lfss_pkg::OP_SCAN:
                begin
                    if (enabled_reg)
                    begin
                        held_next = latest_reg;
                        if (pick.found)
                        begin
                            off_v     = pick.offset;
                            line_next = pick.pos;
                        end
                        else if (line_reg == lfss_pkg::POS_CENTER)
                        begin
                            running_next = 1'b1;
                            if (count_reg >= cfg.stop_ticks)
                            begin
                                halted_next = 1'b1;
                                count_next  = '0;
                                stop_hit    = 1'b1;
                            end
                        end
                        else
                        begin
                            count_next = '0;
                        end

                        if (!stop_hit)
                        begin
                            // same position again, or line lost: widen the turn
                            if (line_reg == line_next)
                                off_v = grow(off_v);
                            offset_next = off_v;
                            off_wide    = lfss_pkg::WIDE_W'(off_v);
                            left_next   = lfss_pkg::sat_duty(
                                $signed({3'b000, base_reg}) - off_wide);
                            right_next  = lfss_pkg::sat_duty(
                                $signed({3'b000, base_reg}) + off_wide);
                        end
                    end
                end
                lfss_pkg::OP_SPEED:
                begin
                    // decrement first, then increment
                    if (held_reg < cfg.min_pulse_sum)
                        base_v = lfss_pkg::sat_duty($signed({3'b000, base_v})
                                 - $signed({3'b000, cfg.speed_down_step}));
                    if (held_reg > cfg.max_pulse_sum)
                        base_v = lfss_pkg::sat_duty($signed({3'b000, base_v})
                                 + $signed({3'b000, cfg.speed_up_step}));
                    base_next   = base_v;
                    latest_next = $signed({left_pulses[lfss_pkg::PULSE_W-1], left_pulses})
                                + $signed({right_pulses[lfss_pkg::PULSE_W-1], right_pulses});
                end
                lfss_pkg::OP_TICK:
                begin
                    if (running_reg && (count_reg != '1))
                        count_next = count_reg + 1'b1;
                end
                lfss_pkg::OP_TOGGLE:
                begin
                    enabled_next = !enabled_reg;
                end
            endcase
        end
    end

    // the result reflects the state after this word
    always_comb
    begin
        res.left_duty      = halted_next ? lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE) : left_next;
        res.right_duty     = halted_next ? lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE) : right_next;
        res.line_position  = line_next;
        res.motors_enabled = enabled_next;
        res.halted         = halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            halted_reg  <= 1'b0;
            running_reg <= 1'b0;
            count_reg   <= '0;
            base_reg    <= lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
            offset_reg  <= '0;
            line_reg    <= lfss_pkg::POS_NONE;
            latest_reg  <= '0;
            held_reg    <= '0;
            left_reg    <= lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
            right_reg   <= lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
        end
        else
        begin
            enabled_reg <= enabled_next;
            halted_reg  <= halted_next;
            running_reg <= running_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            offset_reg  <= offset_next;
            line_reg    <= line_next;
            latest_reg  <= latest_next;
            held_reg    <= held_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
        end
    end

endmodule

### hdl/lfss_out.sv
// Output register with one skid entry behind it.
`timescale 1ns / 1ps

module lfss_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfss_pkg::res_t res_in,
    input  logic           out_stall,
    output logic           out_valid,
    output lfss_pkg::res_t res_out,
    output logic           full
);

    logic           out_valid_reg,  out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    lfss_pkg::res_t out_reg,        out_next;
    lfss_pkg::res_t skid_reg,       skid_next;
    logic           pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            // advance: skid entry first, then the new word
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next       = res_in;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            // hold the output, park the new word
            skid_next       = res_in;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign res_out   = out_reg;
    assign full      = skid_valid_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the line follower steering and speed controller.
`timescale 1ns / 1ps

module testbench;

    // Give up after this many clocks.
    localparam int CYCLE_LIMIT = 200_000;
    // Words per random phase that the block actually acts on.
    localparam int PHASE_WORDS = 80;

    // One input word as the sender sees it.
    typedef struct {
        lfss_pkg::op_t                       op;
        logic [lfss_pkg::ADC_BITS-1:0]       sensor [lfss_pkg::SENSOR_COUNT];
        logic signed [lfss_pkg::PULSE_W-1:0] left;
        logic signed [lfss_pkg::PULSE_W-1:0] right;
    } word_t;

    // Steering predictor: keeps its own copy of the controller state and the
    // register file, and queues the result word that each input word yields.
    class steer_model;
        lfss_pkg::cfg_t                     regs;
        bit                                 enabled;
        bit                                 timer_running;
        bit                                 halted_now;
        logic [lfss_pkg::DUTY_W-1:0]        base;
        logic signed [lfss_pkg::OFF_W-1:0]  offset;
        logic [lfss_pkg::DUTY_W-1:0]        left_drv;
        logic [lfss_pkg::DUTY_W-1:0]        right_drv;
        logic [lfss_pkg::POS_W-1:0]         line_pos;
        logic signed [lfss_pkg::SUM_W-1:0]  latest_sum;
        logic signed [lfss_pkg::SUM_W-1:0]  held_sum;
        logic [lfss_pkg::TICK_W-1:0]        stop_count;
        lfss_pkg::res_t                     expected_duties [$];
        int                                 failures;
        int                                 words_noted;
        int                                 results_seen;
        int                                 enabled_scans;
        int                                 lost_scans;

        function new();
            regs.white_threshold = 12'd1737;
            regs.min_pulse_sum   = 13'sd63;
            regs.max_pulse_sum   = 13'sd188;
            regs.stop_ticks      = 16'd400;
            regs.speed_down_step = 13'd205;
            regs.speed_up_step   = 13'd410;
            regs.near_offset     = 13'd102;
            regs.far_offset      = 13'd328;
            enabled       = 1'b0;
            timer_running = 1'b0;
            halted_now    = 1'b0;
            base          = lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
            offset        = '0;
            left_drv      = lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
            right_drv     = lfss_pkg::DUTY_W'(lfss_pkg::BASE_RESET);
            line_pos      = lfss_pkg::POS_NONE;
            latest_sum    = '0;
            held_sum      = '0;
            stop_count    = '0;
            failures      = 0;
            words_noted   = 0;
            results_seen  = 0;
            enabled_scans = 0;
            lost_scans    = 0;
        endfunction

        function int limit(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

        function void set_reg(logic [lfss_pkg::CFG_IDX_W-1:0] idx, int value);
            case (idx)
                lfss_pkg::CFG_WHITE_THRESHOLD:
                    regs.white_threshold = value[lfss_pkg::ADC_BITS-1:0];
                lfss_pkg::CFG_MIN_PULSE_SUM:
                    regs.min_pulse_sum   = value[lfss_pkg::SUM_W-1:0];
                lfss_pkg::CFG_MAX_PULSE_SUM:
                    regs.max_pulse_sum   = value[lfss_pkg::SUM_W-1:0];
                lfss_pkg::CFG_STOP_TICKS:
                    regs.stop_ticks      = value[lfss_pkg::TICK_W-1:0];
                lfss_pkg::CFG_SPEED_DOWN_STEP:
                    regs.speed_down_step = value[lfss_pkg::DUTY_W-1:0];
                lfss_pkg::CFG_SPEED_UP_STEP:
                    regs.speed_up_step   = value[lfss_pkg::DUTY_W-1:0];
                lfss_pkg::CFG_NEAR_OFFSET:
                    regs.near_offset     = value[lfss_pkg::DUTY_W-1:0];
                default:
                    regs.far_offset      = value[lfss_pkg::DUTY_W-1:0];
            endcase
        endfunction

        // Advance the predicted state by one accepted word and queue its result.
        function void note_word(word_t w);
            logic [lfss_pkg::POS_W-1:0] scan_order [lfss_pkg::SENSOR_COUNT] = '{
                lfss_pkg::POS_CENTER, lfss_pkg::POS_NEAR_LEFT, lfss_pkg::POS_NEAR_RIGHT,
                lfss_pkg::POS_FAR_LEFT, lfss_pkg::POS_FAR_RIGHT};
            logic [lfss_pkg::POS_W-1:0] pick;
            logic [lfss_pkg::POS_W-1:0] prev_pos;
            int                         pick_off;
            longint                     prod;
            longint                     mag;
            bit                         stopped;
            lfss_pkg::res_t             r;

            words_noted++;
            if (!halted_now)
            begin
                case (w.op)
                    lfss_pkg::OP_SCAN:
                        if (enabled)
                        begin
                            enabled_scans++;
                            held_sum = latest_sum;
                            prev_pos = line_pos;
                            pick     = lfss_pkg::POS_NONE;
                            stopped  = 1'b0;
                            foreach (scan_order[k])
                                if (pick == lfss_pkg::POS_NONE &&
                                    w.sensor[scan_order[k]] > regs.white_threshold)
                                    pick = scan_order[k];
                            if (pick != lfss_pkg::POS_NONE)
                            begin
                                case (pick)
                                    lfss_pkg::POS_CENTER:
                                        pick_off = 0;
                                    lfss_pkg::POS_NEAR_LEFT:
                                        pick_off = int'(regs.near_offset);
                                    lfss_pkg::POS_NEAR_RIGHT:
                                        pick_off = -int'(regs.near_offset);
                                    lfss_pkg::POS_FAR_LEFT:
                                        pick_off = int'(regs.far_offset);
                                    default:
                                        pick_off = -int'(regs.far_offset);
                                endcase
                                offset   = lfss_pkg::OFF_W'(limit(pick_off, -lfss_pkg::Q_ONE,
                                                                  lfss_pkg::Q_ONE));
                                line_pos = pick;
                            end
                            else
                            begin
                                lost_scans++;
                                if (prev_pos == lfss_pkg::POS_CENTER)
                                begin
                                    timer_running = 1'b1;
                                    if (stop_count >= regs.stop_ticks)
                                    begin
                                        halted_now = 1'b1;
                                        stop_count = '0;
                                        stopped    = 1'b1;
                                    end
                                end
                                else
                                    stop_count = '0;
                            end
                            if (!stopped)
                            begin
                                // repeated or lost line: scale by 1.1, round half away from zero
                                if (prev_pos == line_pos)
                                begin
                                    prod   = longint'(int'(offset)) * lfss_pkg::GROW_NUM;
                                    mag    = (prod < 0) ? -prod : prod;
                                    mag    = (mag + lfss_pkg::ROUND_HALF) >>> lfss_pkg::FRAC_BITS;
                                    offset = lfss_pkg::OFF_W'(limit(
                                        (prod < 0) ? -int'(mag) : int'(mag),
                                        -lfss_pkg::Q_ONE, lfss_pkg::Q_ONE));
                                end
                                left_drv  = lfss_pkg::DUTY_W'(limit(int'(base) - int'(offset),
                                                                    0, lfss_pkg::Q_ONE));
                                right_drv = lfss_pkg::DUTY_W'(limit(int'(base) + int'(offset),
                                                                    0, lfss_pkg::Q_ONE));
                            end
                        end
                    lfss_pkg::OP_SPEED:
                    begin
                        if (int'(held_sum) < int'($signed(regs.min_pulse_sum)))
                            base = lfss_pkg::DUTY_W'(limit(
                                int'(base) - int'(regs.speed_down_step), 0, lfss_pkg::Q_ONE));
                        if (int'(held_sum) > int'($signed(regs.max_pulse_sum)))
                            base = lfss_pkg::DUTY_W'(limit(
                                int'(base) + int'(regs.speed_up_step), 0, lfss_pkg::Q_ONE));
                        latest_sum = lfss_pkg::SUM_W'(w.left) + lfss_pkg::SUM_W'(w.right);
                    end
                    lfss_pkg::OP_TICK:
                        if (timer_running && stop_count != {lfss_pkg::TICK_W{1'b1}})
                            stop_count++;
                    default:
                        enabled = !enabled;
                endcase
            end

            r.left_duty      = halted_now ? lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE) : left_drv;
            r.right_duty     = halted_now ? lfss_pkg::DUTY_W'(lfss_pkg::Q_ONE) : right_drv;
            r.line_position  = line_pos;
            r.motors_enabled = enabled;
            r.halted         = halted_now;
            expected_duties.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_result(lfss_pkg::res_t got);
            lfss_pkg::res_t want;
            results_seen++;
            if (expected_duties.size() == 0)
            begin
                $error("result word arrived with no prediction pending");
                failures++;
                return;
            end
            want = expected_duties.pop_front();
            if (got.left_duty !== want.left_duty)
            begin
                $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
                failures++;
            end
            if (got.right_duty !== want.right_duty)
            begin
                $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
                failures++;
            end
            if (got.line_position !== want.line_position)
            begin
                $error("line_position: expected %0d, got %0d",
                       want.line_position, got.line_position);
                failures++;
            end
            if (got.motors_enabled !== want.motors_enabled)
            begin
                $error("motors_enabled: expected %0d, got %0d",
                       want.motors_enabled, got.motors_enabled);
                failures++;
            end
            if (got.halted !== want.halted)
            begin
                $error("halted: expected %0d, got %0d", want.halted, got.halted);
                failures++;
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [lfss_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [lfss_pkg::CFG_W-1:0]          cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [1:0]                          operation;
    logic [lfss_pkg::ADC_BITS-1:0]       sensor_0;
    logic [lfss_pkg::ADC_BITS-1:0]       sensor_1;
    logic [lfss_pkg::ADC_BITS-1:0]       sensor_2;
    logic [lfss_pkg::ADC_BITS-1:0]       sensor_3;
    logic [lfss_pkg::ADC_BITS-1:0]       sensor_4;
    logic signed [lfss_pkg::PULSE_W-1:0] left_pulses;
    logic signed [lfss_pkg::PULSE_W-1:0] right_pulses;
    logic                                out_valid;
    logic                                out_stall;
    logic [lfss_pkg::DUTY_W-1:0]         left_duty;
    logic [lfss_pkg::DUTY_W-1:0]         right_duty;
    logic [lfss_pkg::POS_W-1:0]          line_position;
    logic                                motors_enabled;
    logic                                halted;

    steer_model book;
    bit         steady_send  = 1'b0;   // sender runs without gaps while set
    bit         steady_drain = 1'b0;   // receiver runs without stalls while set
    int         cycles       = 0;
    int         settings_run = 0;

    line_follower_steering_speed DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .sensor_0       (sensor_0),
        .sensor_1       (sensor_1),
        .sensor_2       (sensor_2),
        .sensor_3       (sensor_3),
        .sensor_4       (sensor_4),
        .left_pulses    (left_pulses),
        .right_pulses   (right_pulses),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_duty      (left_duty),
        .right_duty     (right_duty),
        .line_position  (line_position),
        .motors_enabled (motors_enabled),
        .halted         (halted)
    );

    always #5 clk = ~clk;

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check every result word taken at a rising edge.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            book.check_result({left_duty, right_duty, line_position, motors_enabled, halted});

    // Receiver: stall for a drawn number of cycles, then take one word.
    // Occasionally flip into a stretch with no stalls at all.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            if ($urandom_range(29, 0) == 0)
                steady_drain = !steady_drain;
            hold = steady_drain ? 0 : $urandom_range(9, 0);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic word_t mk(lfss_pkg::op_t op, int s0, int s1, int s2, int s3, int s4,
                                 int lp = 0, int rp = 0);
        word_t w;
        w.op        = op;
        w.sensor[0] = s0[lfss_pkg::ADC_BITS-1:0];
        w.sensor[1] = s1[lfss_pkg::ADC_BITS-1:0];
        w.sensor[2] = s2[lfss_pkg::ADC_BITS-1:0];
        w.sensor[3] = s3[lfss_pkg::ADC_BITS-1:0];
        w.sensor[4] = s4[lfss_pkg::ADC_BITS-1:0];
        w.left      = lp[lfss_pkg::PULSE_W-1:0];
        w.right     = rp[lfss_pkg::PULSE_W-1:0];
        return w;
    endfunction

    // ADC code on the wanted side of the current threshold. With the threshold
    // at full scale nothing can read white, so hand back full scale.
    function automatic int sensor_code(bit white);
        int thr;
        thr = int'(book.regs.white_threshold);
        if (white)
            return (thr == 4095) ? 4095 : $urandom_range(4095, thr + 1);
        return $urandom_range(thr, 0);
    endfunction

    // Random word shaped like a robot on a track: clean single-sensor scans with
    // the centre favored, lost-line scans, paired hits, plus noise.
    function automatic word_t random_word();
        word_t w;
        int    pick;
        int    mode;
        int    hot;
        w = mk(lfss_pkg::OP_SCAN, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        pick = $urandom_range(99, 0);
        if (pick < 50)
            w.op = lfss_pkg::OP_SCAN;
        else if (pick < 75)
            w.op = lfss_pkg::OP_SPEED;
        else
            w.op = lfss_pkg::OP_TICK;
        // keep the block enabled most of the time
        if ((book.enabled && $urandom_range(99, 0) < 3) ||
            (!book.enabled && $urandom_range(99, 0) < 30))
            w.op = lfss_pkg::OP_TOGGLE;

        if (w.op == lfss_pkg::OP_SCAN)
        begin
            mode = $urandom_range(9, 0);
            hot  = ($urandom_range(1, 0) == 0) ? int'(lfss_pkg::POS_CENTER)
                                               : $urandom_range(4, 0);
            for (int k = 0; k < lfss_pkg::SENSOR_COUNT; k++)
                case (mode)
                    0, 1, 2, 3:
                        w.sensor[k] = lfss_pkg::ADC_BITS'(sensor_code(k == hot));
                    4, 5:
                        w.sensor[k] = lfss_pkg::ADC_BITS'(sensor_code(1'b0));
                    6, 7:
                        w.sensor[k] = lfss_pkg::ADC_BITS'(
                            sensor_code($urandom_range(9, 0) < 3));
                    8:
                        w.sensor[k] = w.sensor[k];
                    default:
                        w.sensor[k] = lfss_pkg::ADC_BITS'(
                            sensor_code(k == hot || k == (hot + 1) % 5));
                endcase
        end
        else if (w.op == lfss_pkg::OP_SPEED && $urandom_range(9, 0) < 6)
        begin
            // small counts land between the limits more often
            w.left  = lfss_pkg::PULSE_W'($urandom_range(256, 0) - 128);
            w.right = lfss_pkg::PULSE_W'($urandom_range(256, 0) - 128);
        end
        return w;
    endfunction

    // Present one word after a drawn gap and hold it until taken.
    task automatic send_word(input word_t w);
        int gap;
        if ($urandom_range(29, 0) == 0)
            steady_send = !steady_send;
        gap = steady_send ? 0 : $urandom_range(9, 0);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation    = w.op;
        sensor_0     = w.sensor[0];
        sensor_1     = w.sensor[1];
        sensor_2     = w.sensor[2];
        sensor_3     = w.sensor[3];
        sensor_4     = w.sensor[4];
        left_pulses  = w.left;
        right_pulses = w.right;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall);
        book.note_word(w);
    endtask

    // Drop valid and hold until every predicted result word has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [lfss_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[lfss_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        book.set_reg(idx, value);
    endtask

    task automatic write_all(input int thr, input int lo_sum, input int hi_sum,
                             input int stop, input int down, input int up,
                             input int near, input int far);
        write_reg(lfss_pkg::CFG_WHITE_THRESHOLD, thr);
        write_reg(lfss_pkg::CFG_MIN_PULSE_SUM, lo_sum);
        write_reg(lfss_pkg::CFG_MAX_PULSE_SUM, hi_sum);
        write_reg(lfss_pkg::CFG_STOP_TICKS, stop);
        write_reg(lfss_pkg::CFG_SPEED_DOWN_STEP, down);
        write_reg(lfss_pkg::CFG_SPEED_UP_STEP, up);
        write_reg(lfss_pkg::CFG_NEAR_OFFSET, near);
        write_reg(lfss_pkg::CFG_FAR_OFFSET, far);
    endtask

    // Random phase: stop on words the block acts on, not on ignored scans.
    // Now and then pause the sender until the pipeline is empty.
    task automatic random_phase();
        word_t w;
        int    acted;
        acted = 0;
        settings_run++;
        while (acted < PHASE_WORDS)
        begin
            w = random_word();
            if (w.op != lfss_pkg::OP_SCAN || book.enabled)
                acted++;
            send_word(w);
            if ($urandom_range(59, 0) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        int lo_sum;
        book = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = lfss_pkg::OP_TICK;
        sensor_0     = '0;
        sensor_1     = '0;
        sensor_2     = '0;
        sensor_3     = '0;
        sensor_4     = '0;
        left_pulses  = '0;
        right_pulses = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on reset settings (threshold 1737).
        // While disabled, scans change nothing; speed samples still latch.
        send_word(mk(lfss_pkg::OP_SCAN, 4095, 4095, 4095, 4095, 4095));
        send_word(mk(lfss_pkg::OP_SPEED, 0, 0, 0, 0, 0, 2047, 2047));
        send_word(mk(lfss_pkg::OP_TICK, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_TOGGLE, 0, 0, 0, 0, 0));
        // centre line, then a fast speed sample raises base drive
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 4095, 0, 0));
        send_word(mk(lfss_pkg::OP_SPEED, 0, 0, 0, 0, 0, -2048, -2048));
        // near-left one code above threshold; centre exactly at it is black
        send_word(mk(lfss_pkg::OP_SCAN, 0, 1738, 1737, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 1738, 0, 0, 0));
        // slow speed sample lowers base drive
        send_word(mk(lfss_pkg::OP_SPEED, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 0, 4095, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 0, 4095, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 4095, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 0, 0, 4095));
        // all white: centre wins the priority
        send_word(mk(lfss_pkg::OP_SCAN, 4095, 4095, 4095, 4095, 4095));
        // lose the line after centre: stop timer starts, no halt yet
        send_word(mk(lfss_pkg::OP_SCAN, 1737, 1737, 1737, 1737, 1737));
        send_word(mk(lfss_pkg::OP_TICK, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_TICK, 0, 0, 0, 0, 0));
        // near-left beats near-right, then lose it twice so the offset grows
        send_word(mk(lfss_pkg::OP_SCAN, 0, 4095, 0, 4095, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_TOGGLE, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 0, 4095, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SPEED, 0, 0, 0, 0, 0, 100, 30));
        send_word(mk(lfss_pkg::OP_TOGGLE, 0, 0, 0, 0, 0));
        drain_results();

        // Random phases over a spread of register settings. Stop ticks stay far
        // above any count the run can build, so the block never halts here.
        random_phase();
        write_all(0, -4096, 4094, 65535, 0, 0, 4096, 4096);
        random_phase();
        // limits crossed both ways at once, full-scale steps, threshold at top
        write_all(4095, 4094, -4096, 1000, 4096, 4096, 0, 0);
        random_phase();
        write_all($urandom_range(4095, 0), $urandom_range(8190, 0) - 4096,
                  $urandom_range(8190, 0) - 4096, $urandom_range(65535, 1000),
                  $urandom_range(4096, 0), $urandom_range(4096, 0),
                  $urandom_range(4096, 0), $urandom_range(4096, 0));
        random_phase();
        lo_sum = $urandom_range(300, 0) - 200;
        write_all($urandom_range(3000, 1000), lo_sum, lo_sum + $urandom_range(400, 0),
                  $urandom_range(65535, 1000), $urandom_range(600, 0),
                  $urandom_range(600, 0), $urandom_range(1000, 0), $urandom_range(1000, 0));
        random_phase();

        // End-of-track stop. First a short stop window that is not reached.
        write_reg(lfss_pkg::CFG_WHITE_THRESHOLD, 2000);
        write_reg(lfss_pkg::CFG_STOP_TICKS, 4);
        settings_run++;
        if (!book.enabled)
            send_word(mk(lfss_pkg::OP_TOGGLE, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 4000, 100, 100, 100));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 100, 100, 100));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 4000, 100, 100));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 100, 100, 100));
        repeat (3) send_word(mk(lfss_pkg::OP_TICK, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 100, 100, 100));
        // found again: timer keeps running; lost after near-left clears the count
        send_word(mk(lfss_pkg::OP_SCAN, 100, 4000, 100, 100, 100));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 100, 100, 100));
        drain_results();

        // Stop ticks of zero: the first loss after centre halts at once.
        write_reg(lfss_pkg::CFG_STOP_TICKS, 0);
        settings_run++;
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 4000, 100, 100));
        send_word(mk(lfss_pkg::OP_SCAN, 100, 100, 100, 100, 100));
        // everything is ignored once halted, the enable toggle too
        send_word(mk(lfss_pkg::OP_TOGGLE, 0, 0, 0, 0, 0));
        send_word(mk(lfss_pkg::OP_SCAN, 4000, 4000, 4000, 4000, 4000));
        send_word(mk(lfss_pkg::OP_SPEED, 0, 0, 0, 0, 0, 2047, 2047));
        send_word(mk(lfss_pkg::OP_TICK, 0, 0, 0, 0, 0));
        drain_results();

        // Let any stray word show up before judging.
        repeat (8) @(posedge clk);
        if (book.pending() != 0)
        begin
            $error("%0d predicted result words never arrived", book.pending());
            book.failures++;
        end

        $display("Ran %0d words through %0d register settings, %0d result words checked.",
                 book.words_noted, settings_run, book.results_seen);
        $display("Scans while enabled: %0d (%0d with the line lost); end-of-track stop %s.",
                 book.enabled_scans, book.lost_scans,
                 book.halted_now ? "reached" : "not reached");
        if (book.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/lfss_pkg.sv
hdl/lfss_lane.sv
hdl/lfss_pick.sv
hdl/lfss_ctrl.sv
hdl/lfss_out.sv
hdl/line_follower_steering_speed.sv
tb/testbench.sv
